// File: rtl/v3n_pkg.sv
`timescale 1ns / 1ps
package v3n_pkg;

	// component and result widths
	localparam int InW   = 32;
	localparam int OutF  = 30;
	localparam int OutW  = OutF + 2;
	// guard bits added under the square root
	localparam int Guard = InW / 2;
	// root bits, sum of squares and radicand widths
	localparam int RootW = InW + Guard;
	localparam int SumW  = 2 * InW;
	localparam int RadW  = 2 * RootW;
	localparam int RemW  = RootW + 1;
	// quotient bits, enough to hold a value just past one
	localparam int QuoW  = OutF + 2;
	localparam int Lanes = 3;

	typedef struct packed {
		logic signed [InW-1:0] x_in;
		logic signed [InW-1:0] y_in;
		logic signed [InW-1:0] z_in;
	} vec_in_t;

	typedef struct packed {
		logic signed [OutW-1:0] x_unit;
		logic signed [OutW-1:0] y_unit;
		logic signed [OutW-1:0] z_unit;
		logic                   zero_vector;
	} vec_out_t;

endpackage

// File: rtl/vector3_normalize.sv
`timescale 1ns / 1ps
// Pipeline: square, sum, 48 root steps, 32 divide steps and clamp, each in
// its own registered stage; a stalled result waits in the skid register.
// Throughput: one vector per cycle while in_stall is low; each step owns a stage.
// Reset: arst_n clears all valid bits; payload registers are not reset.
module vector3_normalize (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  v3n_pkg::vec_in_t   in_beat,
	output logic               out_valid,
	input  logic               out_stall,
	output v3n_pkg::vec_out_t  out_beat
);

	localparam int InW   = v3n_pkg::InW;
	localparam int OutF  = v3n_pkg::OutF;
	localparam int OutW  = v3n_pkg::OutW;
	localparam int Guard = v3n_pkg::Guard;
	localparam int RootW = v3n_pkg::RootW;
	localparam int SumW  = v3n_pkg::SumW;
	localparam int RadW  = v3n_pkg::RadW;
	localparam int RemW  = v3n_pkg::RemW;
	localparam int QuoW  = v3n_pkg::QuoW;
	localparam int Lanes = v3n_pkg::Lanes;

	logic en;
	logic skid_v_q;
	v3n_pkg::vec_out_t skid_q;

	// advance the whole pipe unless the skid register is occupied
	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	// stage 1: magnitudes and squares
	logic                        v_s1;
	logic [Lanes-1:0][InW-1:0]   mag_s1;
	logic [Lanes-1:0]            neg_s1;
	logic [Lanes-1:0][SumW-1:0]  sq_s1;
	logic [Lanes-1:0][InW-1:0]   comp;
	logic [Lanes-1:0][InW-1:0]   mag_c;

	assign comp[0] = in_beat.x_in;
	assign comp[1] = in_beat.y_in;
	assign comp[2] = in_beat.z_in;

	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			mag_c[l] = comp[l][InW-1] ? (~comp[l] + InW'(1)) : comp[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < Lanes; l++) begin
				mag_s1[l] <= mag_c[l];
				neg_s1[l] <= comp[l][InW-1];
				sq_s1[l]  <= mag_c[l] * mag_c[l];
			end
		end
	end

	// stage 2: sum of squares and zero test
	logic                       v_s2;
	logic [Lanes-1:0][InW-1:0]  mag_s2;
	logic [Lanes-1:0]           neg_s2;
	logic [SumW-1:0]            sum_s2;
	logic                       zero_s2;
	logic [SumW-1:0]            sum_c;

	assign sum_c = sq_s1[0] + sq_s1[1] + sq_s1[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			sum_s2  <= sum_c;
			zero_s2 <= (sum_c == '0);
		end
	end

	// root stages: one root bit per stage, two radicand bits consumed
	logic                       rt_v    [RootW+1];
	logic [RadW-1:0]            rt_rad  [RootW+1];
	logic [RemW-1:0]            rt_rem  [RootW+1];
	logic [RootW-1:0]           rt_root [RootW+1];
	logic [Lanes-1:0][InW-1:0]  rt_mag  [RootW+1];
	logic [Lanes-1:0]           rt_neg  [RootW+1];
	logic                       rt_zero [RootW+1];

	assign rt_v[0]    = v_s2;
	assign rt_rad[0]  = {sum_s2, (RadW - SumW)'(0)};
	assign rt_rem[0]  = '0;
	assign rt_root[0] = '0;
	assign rt_mag[0]  = mag_s2;
	assign rt_neg[0]  = neg_s2;
	assign rt_zero[0] = zero_s2;

	for (genvar i = 0; i < RootW; i++) begin : g_root
		logic [RemW+1:0] cur;
		logic [RemW+1:0] trial;
		logic            take;

		assign cur   = {rt_rem[i], rt_rad[i][RadW-1 -: 2]};
		assign trial = (RemW+2)'({rt_root[i], 2'b01});
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[i+1] <= 1'b0;
			end else if (en) begin
				rt_v[i+1] <= rt_v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rad[i+1]  <= {rt_rad[i][RadW-3:0], 2'b00};
				rt_rem[i+1]  <= take ? RemW'(cur - trial) : RemW'(cur);
				rt_root[i+1] <= {rt_root[i][RootW-2:0], take};
				rt_mag[i+1]  <= rt_mag[i];
				rt_neg[i+1]  <= rt_neg[i];
				rt_zero[i+1] <= rt_zero[i];
			end
		end
	end

	// divide stages: one quotient bit per stage in each of the three lanes
	logic                         dv_v    [QuoW+1];
	logic [Lanes-1:0][RootW-1:0]  dv_rem  [QuoW+1];
	logic [Lanes-1:0][QuoW-1:0]   dv_quo  [QuoW+1];
	logic [RootW-1:0]             dv_root [QuoW+1];
	logic [Lanes-1:0]             dv_neg  [QuoW+1];
	logic                         dv_zero [QuoW+1];

	assign dv_v[0]    = rt_v[RootW];
	assign dv_root[0] = rt_root[RootW];
	assign dv_neg[0]  = rt_neg[RootW];
	assign dv_zero[0] = rt_zero[RootW];

	for (genvar l = 0; l < Lanes; l++) begin : g_init
		assign dv_rem[0][l] = RootW'({rt_mag[RootW][l], (Guard-2)'(0)});
		assign dv_quo[0][l] = '0;
	end

	for (genvar j = 0; j < QuoW; j++) begin : g_div
		logic [Lanes-1:0][RootW:0] sh;
		logic [Lanes-1:0]          take;

		always_comb begin
			for (int l = 0; l < Lanes; l++) begin
				sh[l]   = {dv_rem[j][l], 1'b0};
				take[l] = (sh[l] >= {1'b0, dv_root[j]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < Lanes; l++) begin
					dv_rem[j+1][l] <= take[l] ? RootW'(sh[l] - {1'b0, dv_root[j]})
					                          : RootW'(sh[l]);
					dv_quo[j+1][l] <= {dv_quo[j][l][QuoW-2:0], take[l]};
				end
				dv_root[j+1] <= dv_root[j];
				dv_neg[j+1]  <= dv_neg[j];
				dv_zero[j+1] <= dv_zero[j];
			end
		end
	end

	// final stage: clamp to one, apply sign, force zero on a null vector
	logic                        fin_v_s;
	v3n_pkg::vec_out_t           fin_s;
	logic [Lanes-1:0][OutW-1:0]  res_c;

	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			logic [QuoW-1:0] q;
			q = dv_quo[QuoW][l];
			if (q > (QuoW'(1) << OutF)) begin
				q = QuoW'(1) << OutF;
			end
			if (dv_zero[QuoW]) begin
				res_c[l] = '0;
			end else if (dv_neg[QuoW][l]) begin
				res_c[l] = OutW'(~q + QuoW'(1));
			end else begin
				res_c[l] = OutW'(q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s <= 1'b0;
		end else if (en) begin
			fin_v_s <= dv_v[QuoW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s.x_unit      <= res_c[0];
			fin_s.y_unit      <= res_c[1];
			fin_s.z_unit      <= res_c[2];
			fin_s.zero_vector <= dv_zero[QuoW];
		end
	end

	// skid: park a stalled result; the pipe halts while the skid register is occupied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			skid_v_q <= out_stall;
		end else begin
			skid_v_q <= fin_v_s && out_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= fin_s;
		end
	end

	assign out_valid = skid_v_q || fin_v_s;
	assign out_beat  = skid_v_q ? skid_q : fin_s;

endmodule
